// ===== rtl/table_driven_group_fsm_relay_control_defines.svh =====
// ---------------------------------------------------------------------------
// Relay control assertion macros
// Shared assertion forms for the relay control checker.
// ---------------------------------------------------------------------------
`ifndef TABLE_DRIVEN_GROUP_FSM_RELAY_CONTROL_DEFINES_SVH
`define TABLE_DRIVEN_GROUP_FSM_RELAY_CONTROL_DEFINES_SVH

// Check cons in the same cycle as ante.
`define TDGFSM_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("relay control assertion failed");

// Check cons in the cycle after ante.
`define TDGFSM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("relay control assertion failed");

`endif

// ===== rtl/tdgfsm_pkg.sv =====
// ---------------------------------------------------------------------------
// Relay control package
// Types, codes and default sizes shared by the relay control modules.
// ---------------------------------------------------------------------------
package tdgfsm_pkg;

  localparam int NUM_GROUPS_DEF       = 8;
  localparam int NUM_RELAYS_DEF       = 8;
  localparam int STATE_DEPTH_DEF      = 64;
  localparam int TRANSITION_DEPTH_DEF = 256;

  localparam logic [15:0] END_MARK = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_MESSAGE  = 2'd0,
    OP_WR_GROUP = 2'd1,
    OP_WR_STATE = 2'd2,
    OP_WR_TRANS = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CMD_MESSAGE,
    CMD_WR_GROUP,
    CMD_WR_STATE,
    CMD_WR_TRANS,
    CMD_DROP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  entry_index;
    logic [7:0]  src_device;
    logic [7:0]  src_input;
    logic [7:0]  message_type;
    logic [5:0]  target_state;
    logic [15:0] table_start;
    logic [7:0]  output_bits;
  } cmd_t;

  typedef struct packed {
    logic [15:0] start;
    logic [7:0]  mask;
  } grp_entry_t;

  typedef struct packed {
    logic [15:0] start;
    logic [7:0]  bits;
  } st_entry_t;

  typedef struct packed {
    logic [7:0] src_device;
    logic [7:0] src_input;
    logic [7:0] message_type;
    logic [5:0] target_state;
  } tr_entry_t;

endpackage

// ===== rtl/table_driven_group_fsm_relay_control.sv =====
// A write transaction is applied when the back end pops it from the queue and
// its result is registered. A message visits each group in turn and scans the
// transitions of that group's current state one at a time through the single
// read port of the transition memory, updating state and relays on a match.
// Results come back in order, one per transaction; two transactions may queue ahead.
// ---------------------------------------------------------------------------
// Table driven group relay control
// Group/state/transition tables loaded by transaction, messages step groups.
// ---------------------------------------------------------------------------
module table_driven_group_fsm_relay_control #(
  parameter int NUM_GROUPS       = tdgfsm_pkg::NUM_GROUPS_DEF,
  parameter int NUM_RELAYS       = tdgfsm_pkg::NUM_RELAYS_DEF,
  parameter int STATE_DEPTH      = tdgfsm_pkg::STATE_DEPTH_DEF,
  parameter int TRANSITION_DEPTH = tdgfsm_pkg::TRANSITION_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  entry_index_i,
  input  logic [7:0]  src_device_i,
  input  logic [7:0]  src_input_i,
  input  logic [7:0]  message_type_i,
  input  logic [5:0]  target_state_i,
  input  logic [15:0] table_start_i,
  input  logic [7:0]  output_bits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  relay_levels_o,
  output logic        state_fault_o
);
  import tdgfsm_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic pop;

  tdgfsm_front #(
    .NUM_GROUPS      (NUM_GROUPS),
    .STATE_DEPTH     (STATE_DEPTH),
    .TRANSITION_DEPTH(TRANSITION_DEPTH)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .operation_i,
    .entry_index_i,
    .src_device_i,
    .src_input_i,
    .message_type_i,
    .target_state_i,
    .table_start_i,
    .output_bits_i,
    .pop_i      (pop),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd)
  );

  tdgfsm_back #(
    .NUM_GROUPS      (NUM_GROUPS),
    .NUM_RELAYS      (NUM_RELAYS),
    .STATE_DEPTH     (STATE_DEPTH),
    .TRANSITION_DEPTH(TRANSITION_DEPTH)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .pop_o      (pop),
    .out_valid_o,
    .out_stall_i,
    .relay_levels_o,
    .state_fault_o
  );

endmodule

// ===== rtl/tdgfsm_front.sv =====
// ---------------------------------------------------------------------------
// Relay control front end
// Accepts transactions, classifies them and queues them for the back end.
// ---------------------------------------------------------------------------
module tdgfsm_front #(
  parameter int NUM_GROUPS       = tdgfsm_pkg::NUM_GROUPS_DEF,
  parameter int STATE_DEPTH      = tdgfsm_pkg::STATE_DEPTH_DEF,
  parameter int TRANSITION_DEPTH = tdgfsm_pkg::TRANSITION_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        operation_i,
  input  logic [7:0]        entry_index_i,
  input  logic [7:0]        src_device_i,
  input  logic [7:0]        src_input_i,
  input  logic [7:0]        message_type_i,
  input  logic [5:0]        target_state_i,
  input  logic [15:0]       table_start_i,
  input  logic [7:0]        output_bits_i,
  input  logic              pop_i,
  output logic              cmd_valid_o,
  output tdgfsm_pkg::cmd_t  cmd_o
);
  import tdgfsm_pkg::*;

  cmd_t       cmd_in;
  cmd_t       fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  logic       pop;

  always_comb begin
    cmd_in.entry_index  = entry_index_i;
    cmd_in.src_device   = src_device_i;
    cmd_in.src_input    = src_input_i;
    cmd_in.message_type = message_type_i;
    cmd_in.target_state = target_state_i;
    cmd_in.table_start  = table_start_i;
    cmd_in.output_bits  = output_bits_i;
    case (op_e'(operation_i))
      OP_MESSAGE:  cmd_in.kind = CMD_MESSAGE;
      OP_WR_GROUP: cmd_in.kind = (32'(entry_index_i) < NUM_GROUPS) ? CMD_WR_GROUP : CMD_DROP;
      OP_WR_STATE: cmd_in.kind = (32'(entry_index_i) <= STATE_DEPTH) ? CMD_WR_STATE : CMD_DROP;
      OP_WR_TRANS: cmd_in.kind = (32'(entry_index_i) < TRANSITION_DEPTH) ?
                                 CMD_WR_TRANS : CMD_DROP;
      default:     cmd_in.kind = CMD_DROP;
    endcase
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ===== rtl/tdgfsm_back.sv =====
// ---------------------------------------------------------------------------
// Relay control back end
// Holds the tables, walks groups and transitions, drives the result.
// ---------------------------------------------------------------------------
module tdgfsm_back #(
  parameter int NUM_GROUPS       = tdgfsm_pkg::NUM_GROUPS_DEF,
  parameter int NUM_RELAYS       = tdgfsm_pkg::NUM_RELAYS_DEF,
  parameter int STATE_DEPTH      = tdgfsm_pkg::STATE_DEPTH_DEF,
  parameter int TRANSITION_DEPTH = tdgfsm_pkg::TRANSITION_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  tdgfsm_pkg::cmd_t  cmd_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        relay_levels_o,
  output logic              state_fault_o
);
  import tdgfsm_pkg::*;

  localparam int GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int SW = $clog2(STATE_DEPTH + 1);
  localparam int TW = $clog2(TRANSITION_DEPTH);
  localparam logic [GW-1:0] GONE = GW'(1);
  localparam logic [GW-1:0] GLAST = GW'(NUM_GROUPS - 1);
  localparam logic [TW:0]   JONE = (TW+1)'(1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GRP,
    ST_NXT,
    ST_CHK,
    ST_ST0,
    ST_ST1,
    ST_TCMP,
    ST_UPD
  } state_e;

  grp_entry_t grp_mem [NUM_GROUPS];
  st_entry_t  st_mem  [STATE_DEPTH + 1];
  tr_entry_t  tr_mem  [TRANSITION_DEPTH];
  grp_entry_t grp_rd_q;
  st_entry_t  st_rd_q;
  tr_entry_t  tr_rd_q;
  logic [GW-1:0] grp_raddr;
  logic [SW-1:0] st_raddr;
  logic [TW-1:0] tr_raddr;

  state_e          state_q, state_d;
  logic [GW-1:0]   g_q, g_d;
  logic [15:0]     base_q, base_d;
  logic [7:0]      mask_q, mask_d;
  logic [15:0]     next_start_q, next_start_d;
  logic            last_q, last_d;
  logic [15:0]     t0_q, t0_d;
  logic [TW:0]     j_q, j_d;
  logic [TW:0]     t1_q, t1_d;
  logic [7:0]      msg_dev_q, msg_dev_d;
  logic [7:0]      msg_input_q, msg_input_d;
  logic [7:0]      msg_kind_q, msg_kind_d;
  logic [5:0]      cur_q [NUM_GROUPS];
  logic [5:0]      cur_d [NUM_GROUPS];
  logic [NUM_RELAYS-1:0] relay_q, relay_d;
  logic            fault_q, fault_d;
  logic            out_valid_q, out_valid_d;

  logic            start;
  logic [16:0]     idx;
  logic [16:0]     nidx;
  logic [TW:0]     t1_clip;
  logic [TW:0]     j_inc;
  logic            tr_match;
  logic [NUM_RELAYS-1:0] m;

  assign start   = (state_q == ST_IDLE) && cmd_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o   = start;
  assign idx     = 17'(base_q) + 17'(cur_q[g_q]);
  assign nidx    = 17'(base_q) + 17'(tr_rd_q.target_state);
  assign t1_clip = (32'(st_rd_q.start) > TRANSITION_DEPTH) ?
                   (TW+1)'(TRANSITION_DEPTH) : (TW+1)'(st_rd_q.start);
  assign j_inc   = j_q + JONE;
  assign m       = mask_q[NUM_RELAYS-1:0];
  assign tr_match = (tr_rd_q.src_device == msg_dev_q) &&
                    (tr_rd_q.src_input == msg_input_q) &&
                    (tr_rd_q.message_type == msg_kind_q);

  assign out_valid_o    = out_valid_q;
  assign relay_levels_o = 8'(relay_q);
  assign state_fault_o  = fault_q;

  always_comb begin
    state_d      = state_q;
    g_d          = g_q;
    base_d       = base_q;
    mask_d       = mask_q;
    next_start_d = next_start_q;
    last_d       = last_q;
    t0_d         = t0_q;
    j_d          = j_q;
    t1_d         = t1_q;
    msg_dev_d    = msg_dev_q;
    msg_input_d  = msg_input_q;
    msg_kind_d   = msg_kind_q;
    cur_d        = cur_q;
    relay_d      = relay_q;
    fault_d      = fault_q;
    out_valid_d  = out_valid_q && out_stall_i;
    grp_raddr    = '0;
    st_raddr     = '0;
    tr_raddr     = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (cmd_i.kind == CMD_MESSAGE) begin
            msg_dev_d   = cmd_i.src_device;
            msg_input_d = cmd_i.src_input;
            msg_kind_d  = cmd_i.message_type;
            g_d         = '0;
            state_d     = ST_GRP;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      ST_GRP: begin
        base_d = grp_rd_q.start;
        mask_d = grp_rd_q.mask;
        if (grp_rd_q.start == END_MARK) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else if (g_q == GLAST) begin
          last_d  = 1'b1;
          state_d = ST_CHK;
        end else begin
          last_d    = 1'b0;
          grp_raddr = g_q + GONE;
          state_d   = ST_NXT;
        end
      end
      ST_NXT: begin
        next_start_d = grp_rd_q.start;
        state_d      = ST_CHK;
      end
      ST_CHK: begin
        if ((!last_q && idx >= 17'(next_start_q)) || idx >= 17'(STATE_DEPTH)) begin
          fault_d     = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          st_raddr = SW'(idx);
          state_d  = ST_ST0;
        end
      end
      ST_ST0: begin
        t0_d     = st_rd_q.start;
        st_raddr = SW'(idx + 17'd1);
        state_d  = ST_ST1;
      end
      ST_ST1: begin
        if (32'(t0_q) < 32'(t1_clip)) begin
          j_d      = (TW+1)'(t0_q);
          t1_d     = t1_clip;
          tr_raddr = TW'(t0_q);
          state_d  = ST_TCMP;
        end else if (g_q == GLAST) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          g_d       = g_q + GONE;
          grp_raddr = g_q + GONE;
          state_d   = ST_GRP;
        end
      end
      ST_TCMP: begin
        if (tr_match) begin
          cur_d[g_q] = tr_rd_q.target_state;
          if (nidx <= 17'(STATE_DEPTH)) begin
            st_raddr = SW'(nidx);
            state_d  = ST_UPD;
          end else if (g_q == GLAST) begin
            out_valid_d = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            g_d       = g_q + GONE;
            grp_raddr = g_q + GONE;
            state_d   = ST_GRP;
          end
        end else if (j_inc < t1_q) begin
          j_d      = j_inc;
          tr_raddr = TW'(j_inc);
        end else if (g_q == GLAST) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          g_d       = g_q + GONE;
          grp_raddr = g_q + GONE;
          state_d   = ST_GRP;
        end
      end
      ST_UPD: begin
        relay_d = (relay_q & ~m) | (st_rd_q.bits[NUM_RELAYS-1:0] & m);
        if (g_q == GLAST) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          g_d       = g_q + GONE;
          grp_raddr = g_q + GONE;
          state_d   = ST_GRP;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      g_q          <= '0;
      base_q       <= '0;
      mask_q       <= '0;
      next_start_q <= '0;
      last_q       <= 1'b0;
      t0_q         <= '0;
      j_q          <= '0;
      t1_q         <= '0;
      msg_dev_q    <= '0;
      msg_input_q  <= '0;
      msg_kind_q   <= '0;
      cur_q        <= '{default: '0};
      relay_q      <= '0;
      fault_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      g_q          <= g_d;
      base_q       <= base_d;
      mask_q       <= mask_d;
      next_start_q <= next_start_d;
      last_q       <= last_d;
      t0_q         <= t0_d;
      j_q          <= j_d;
      t1_q         <= t1_d;
      msg_dev_q    <= msg_dev_d;
      msg_input_q  <= msg_input_d;
      msg_kind_q   <= msg_kind_d;
      cur_q        <= cur_d;
      relay_q      <= relay_d;
      fault_q      <= fault_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && cmd_i.kind == CMD_WR_GROUP) begin
      grp_mem[GW'(cmd_i.entry_index)] <= '{start: cmd_i.table_start, mask: cmd_i.output_bits};
    end
    grp_rd_q <= grp_mem[grp_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (start && cmd_i.kind == CMD_WR_STATE) begin
      st_mem[SW'(cmd_i.entry_index)] <= '{start: cmd_i.table_start, bits: cmd_i.output_bits};
    end
    st_rd_q <= st_mem[st_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (start && cmd_i.kind == CMD_WR_TRANS) begin
      tr_mem[TW'(cmd_i.entry_index)] <= '{src_device: cmd_i.src_device,
                                          src_input: cmd_i.src_input,
                                          message_type: cmd_i.message_type,
                                          target_state: cmd_i.target_state};
    end
    tr_rd_q <= tr_mem[tr_raddr];
  end

endmodule

// ===== rtl/tdgfsm_checker.sv =====
// ---------------------------------------------------------------------------
// Relay control checker
// Port level assertions for the relay control block.
// ---------------------------------------------------------------------------
`include "table_driven_group_fsm_relay_control_defines.svh"

module tdgfsm_checker #(
  parameter int NUM_RELAYS = tdgfsm_pkg::NUM_RELAYS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  relay_levels_o,
  input logic        state_fault_o
);

  logic [7:0] high_relays;

  assign high_relays = relay_levels_o >> NUM_RELAYS;

  `TDGFSM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(relay_levels_o) && $stable(state_fault_o))
  `TDGFSM_ASSERT_NEXT(a_fault_sticky, clk_i, rst_ni, state_fault_o, state_fault_o)
  `TDGFSM_ASSERT_NOW(a_unused_relays_low, clk_i, rst_ni, 1'b1, high_relays == 8'd0)

endmodule

bind table_driven_group_fsm_relay_control tdgfsm_checker #(
  .NUM_RELAYS(NUM_RELAYS)
) u_tdgfsm_checker (.*);

// ===== tb/tb_table_driven_group_fsm_relay_control.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Relay control testbench
// Loads group, state and transition tables, then steps the groups with
// directed and random messages under random input gaps and output stalls.
// A scoreboard predicts relay levels and the sticky fault flag for every
// transaction and checks each returned result in order.
// ---------------------------------------------------------------------------
module tb_table_driven_group_fsm_relay_control;
  import tdgfsm_pkg::*;

  localparam int NG = NUM_GROUPS_DEF;
  localparam int SD = STATE_DEPTH_DEF;
  localparam int TD = TRANSITION_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 20000000;

  typedef struct {
    op_e         op;
    logic [7:0]  entry_index;
    logic [7:0]  src_device;
    logic [7:0]  src_input;
    logic [7:0]  message_type;
    logic [5:0]  target_state;
    logic [15:0] table_start;
    logic [7:0]  output_bits;
  } item_t;

  typedef struct {
    logic [7:0] relays;
    logic       fault;
  } relay_out_t;

  class relay_scoreboard;
    logic [15:0] grp_start[NG];
    logic [7:0]  grp_mask[NG];
    logic [15:0] st_start[SD + 1];
    logic [7:0]  st_bits[SD + 1];
    tr_entry_t   trans[TD];
    logic [5:0]  cur_state[NG];
    logic [7:0]  relays;
    logic        fault;
    relay_out_t  expected_q[$];
    int          errors;

    function new();
      foreach (cur_state[g]) cur_state[g] = '0;
      relays = '0;
      fault  = 1'b0;
      errors = 0;
    endfunction

    function void step_groups(logic [7:0] dev, logic [7:0] inp, logic [7:0] kind);
      int base;
      int idx;
      int t0;
      int t1;
      int nidx;
      for (int g = 0; g < NG; g++) begin
        if (grp_start[g] == END_MARK) return;
        base = int'(grp_start[g]);
        idx  = base + int'(cur_state[g]);
        if ((g + 1 < NG && idx >= int'(grp_start[g+1])) || idx >= SD) begin
          fault = 1'b1;
          return;
        end
        t0 = int'(st_start[idx]);
        t1 = int'(st_start[idx+1]);
        if (t1 > TD) t1 = TD;
        for (int j = t0; j < t1; j++) begin
          if (trans[j].src_device == dev && trans[j].src_input == inp &&
              trans[j].message_type == kind) begin
            cur_state[g] = trans[j].target_state;
            nidx = base + int'(cur_state[g]);
            if (nidx <= SD)
              relays = (relays & ~grp_mask[g]) | (st_bits[nidx] & grp_mask[g]);
            break;
          end
        end
      end
    endfunction

    function void note_item(item_t it);
      relay_out_t e;
      case (it.op)
        OP_MESSAGE: step_groups(it.src_device, it.src_input, it.message_type);
        OP_WR_GROUP: begin
          if (it.entry_index < NG) begin
            grp_start[it.entry_index] = it.table_start;
            grp_mask[it.entry_index]  = it.output_bits;
          end
        end
        OP_WR_STATE: begin
          if (it.entry_index <= SD) begin
            st_start[it.entry_index] = it.table_start;
            st_bits[it.entry_index]  = it.output_bits;
          end
        end
        default: begin
          trans[it.entry_index] = {it.src_device, it.src_input, it.message_type,
                                   it.target_state};
        end
      endcase
      e.relays = relays;
      e.fault  = fault;
      expected_q.push_back(e);
    endfunction

    function void check_result(logic [7:0] r, logic f);
      relay_out_t e;
      if (expected_q.size() == 0) begin
        $error("result with no transaction pending: relay_levels %h", r);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (r !== e.relays) begin
        $error("relay_levels expected %h actual %h", e.relays, r);
        errors++;
      end
      if (f !== e.fault) begin
        $error("state_fault expected %b actual %b", e.fault, f);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  operation_i = '0;
  logic [7:0]  entry_index_i = '0;
  logic [7:0]  src_device_i = '0;
  logic [7:0]  src_input_i = '0;
  logic [7:0]  message_type_i = '0;
  logic [5:0]  target_state_i = '0;
  logic [15:0] table_start_i = '0;
  logic [7:0]  output_bits_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  relay_levels_o;
  logic        state_fault_o;

  relay_scoreboard sb = new();
  int  idle_odds = 0;
  int  stall_left = 0;
  int  cycles = 0;
  bit  wide_targets = 0;

  table_driven_group_fsm_relay_control i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .operation_i, .entry_index_i,
    .src_device_i, .src_input_i, .message_type_i, .target_state_i, .table_start_i,
    .output_bits_i, .out_valid_o, .out_stall_i, .relay_levels_o, .state_fault_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_table_driven_group_fsm_relay_control: done, errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (idle_odds > 0 && $urandom_range(0, idle_odds) == 0) begin
      stall_left = $urandom_range(1, 11);
    end
    out_stall_i <= (stall_left > 0);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(relay_levels_o, state_fault_o);
  end

  task automatic send_item(item_t it);
    if (idle_odds > 0 && $urandom_range(0, idle_odds) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= it.op;
    entry_index_i  <= it.entry_index;
    src_device_i   <= it.src_device;
    src_input_i    <= it.src_input;
    message_type_i <= it.message_type;
    target_state_i <= it.target_state;
    table_start_i  <= it.table_start;
    output_bits_i  <= it.output_bits;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(it);
  endtask

  function automatic item_t make_item(op_e op, int ix, int start, int bits);
    item_t it;
    it.op           = op;
    it.entry_index  = 8'(ix);
    it.src_device   = 8'($urandom);
    it.src_input    = 8'($urandom);
    it.message_type = 8'($urandom);
    it.target_state = 6'($urandom);
    it.table_start  = 16'(start);
    it.output_bits  = 8'(bits);
    return it;
  endfunction

  task automatic send_transition(int ix);
    item_t it;
    it = make_item(OP_WR_TRANS, ix, $urandom, $urandom);
    it.src_device   = 8'($urandom_range(0, 3));
    it.src_input    = 8'($urandom_range(0, 3));
    it.message_type = 8'($urandom_range(0, 3));
    it.target_state = (wide_targets && $urandom_range(0, 7) == 0) ?
                      6'($urandom_range(0, 63)) : 6'($urandom_range(0, 7));
    send_item(it);
  endtask

  task automatic send_message(bit wide);
    item_t it;
    it = make_item(OP_MESSAGE, $urandom, $urandom, $urandom);
    if (!wide) begin
      it.src_device   = 8'($urandom_range(0, 3));
      it.src_input    = 8'($urandom_range(0, 3));
      it.message_type = 8'($urandom_range(0, 3));
    end
    send_item(it);
  endtask

  // eight states per group, group list ends after active groups
  task automatic load_groups(int active);
    for (int g = 0; g < NG; g++)
      send_item(make_item(OP_WR_GROUP, g, (g < active) ? g * 8 : END_MARK, $urandom));
  endtask

  task automatic random_traffic(int count, bit noisy);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_message(pick < 6);
      end else if (pick < 82) begin
        send_transition($urandom_range(0, TD - 1));
      end else if (pick < 88) begin
        send_item(make_item(OP_WR_STATE, $urandom_range(0, SD - 1),
                            $urandom_range(0, SD - 1) * 4, $urandom));
      end else if (pick < 94) begin
        send_item(make_item(OP_WR_GROUP, $urandom_range(NG, 255), $urandom, $urandom));
      end else if (!noisy) begin
        send_item(make_item(OP_WR_STATE, $urandom_range(SD + 1, 255), $urandom, $urandom));
      end else begin
        send_item(make_item(op_e'($urandom_range(1, 2)), $urandom_range(0, SD),
                            $urandom, $urandom));
      end
    end
  endtask

  initial begin
    item_t it;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_odds = 0;
    load_groups(NG);
    for (int s = 0; s <= SD; s++)
      send_item(make_item(OP_WR_STATE, s, s * 4, $urandom));
    for (int t = 0; t < TD; t++) send_transition(t);

    // directed: ignored writes, field extremes, empty and reversed spans
    send_item(make_item(OP_WR_GROUP, NG, 16'hFFFF, 8'hFF));
    send_item(make_item(OP_WR_GROUP, 255, 16'h0000, 8'h00));
    send_item(make_item(OP_WR_STATE, SD + 1, 16'hFFFF, 8'hFF));
    send_item(make_item(OP_WR_STATE, 255, 16'h0000, 8'h00));
    it = make_item(OP_MESSAGE, 0, 0, 0);
    it.src_device = 8'hFF; it.src_input = 8'hFF; it.message_type = 8'hFF;
    send_item(it);
    it.src_device = 8'h00; it.src_input = 8'h00; it.message_type = 8'h00;
    send_item(it);
    send_item(make_item(OP_WR_STATE, 1, 4, 8'hFF));
    send_item(make_item(OP_WR_STATE, 2, 4, 8'h00));
    send_item(make_item(OP_WR_STATE, 3, 2, 8'hA5));
    for (int k = 0; k < 4; k++) send_message(0);
    send_item(make_item(OP_WR_GROUP, 0, END_MARK, 8'hFF));
    send_message(0);
    load_groups(1);
    for (int k = 0; k < 3; k++) send_message(0);
    load_groups(NG);

    for (int ph = 0; ph < 5; ph++) begin
      idle_odds = (ph == 1) ? 0 : (ph == 2 ? 3 : 12);
      load_groups($urandom_range(1, NG));
      for (int s = 0; s <= SD; s++)
        if ($urandom_range(0, 3) == 0)
          send_item(make_item(OP_WR_STATE, s, s * 4, $urandom));
      random_traffic(210, 0);
    end

    // out-of-range targets and corrupt layouts, sticky fault
    wide_targets = 1;
    idle_odds = 6;
    load_groups(NG);
    random_traffic(250, 1);
    idle_odds = 0;
    random_traffic(150, 1);

    in_valid_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0)
      $display("tb_table_driven_group_fsm_relay_control: done, clean");
    else
      $display("tb_table_driven_group_fsm_relay_control: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tdgfsm_pkg.sv
rtl/tdgfsm_front.sv
rtl/tdgfsm_back.sv
rtl/table_driven_group_fsm_relay_control.sv
rtl/tdgfsm_checker.sv
tb/tb_table_driven_group_fsm_relay_control.sv
